[src/qapm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qapm_pkg
// Shared types, register codes and width helpers for the attitude PID mixer.
// ----------------------------------------------------------------------------
package qapm_pkg;

  // Default control tick rate
  localparam int unsigned TICKS_DEFAULT = 1000;

  // Fixed field widths
  localparam int unsigned DATA_W = 16;  // input fields and motor commands
  localparam int unsigned ERR_W  = 17;  // setpoint minus angle, Q8.8
  localparam int unsigned NUM_W  = 21;  // 7*e - 4*prev
  localparam int unsigned ACC_W  = 25;  // integral, Q8.16
  localparam int unsigned GAIN_W = 16;  // Q4.12 gains
  localparam int unsigned LIM_W  = 15;  // integral limit, Q7.8

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_KP_RP   = 3'd0,
    REG_KI_RP   = 3'd1,
    REG_KD_RP   = 3'd2,
    REG_KP_YAW  = 3'd3,
    REG_KI_YAW  = 3'd4,
    REG_KD_YAW  = 3'd5,
    REG_LIM_RP  = 3'd6,
    REG_LIM_YAW = 3'd7
  } cfg_reg_e;

  // Register reset values
  localparam logic [GAIN_W-1:0] KP_RP_RST   = 16'd5734;
  localparam logic [GAIN_W-1:0] KI_RP_RST   = 16'd164;
  localparam logic [GAIN_W-1:0] KD_RP_RST   = 16'd492;
  localparam logic [GAIN_W-1:0] KP_YAW_RST  = 16'd8192;
  localparam logic [GAIN_W-1:0] KI_YAW_RST  = 16'd82;
  localparam logic [GAIN_W-1:0] KD_YAW_RST  = 16'd205;
  localparam logic [LIM_W-1:0]  LIM_RP_RST  = 15'd12800;
  localparam logic [LIM_W-1:0]  LIM_YAW_RST = 15'd7680;

  // Gain set for one loop
  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]  limit;
  } gain_t;

  // Width of the unrounded loop sum (kd*ticks*num*128 dominates)
  function automatic int unsigned loop_sum_w(input int unsigned ticks);
    return $clog2(ticks + 1) + 46;
  endfunction

  // Width of one signed loop output after the divide by 20480
  function automatic int unsigned loop_out_w(input int unsigned ticks);
    return loop_sum_w(ticks) - 11;
  endfunction

endpackage
`default_nettype wire

[src/qapm_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qapm_cfg_regs
// APB register file holding the roll/pitch and yaw gain sets.
// ----------------------------------------------------------------------------
module qapm_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [qapm_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [qapm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [qapm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output qapm_pkg::gain_t                      rp_gain_o,
  output qapm_pkg::gain_t                      yaw_gain_o
);
  import qapm_pkg::*;

  gain_t    rp_q, yaw_q;
  logic     wr_en;
  cfg_reg_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '{kp: KP_RP_RST,  ki: KI_RP_RST,  kd: KD_RP_RST,  limit: LIM_RP_RST};
      yaw_q <= '{kp: KP_YAW_RST, ki: KI_YAW_RST, kd: KD_YAW_RST, limit: LIM_YAW_RST};
    end else if (wr_en) begin
      unique case (sel)
        REG_KP_RP:   rp_q.kp     <= pwdata[GAIN_W-1:0];
        REG_KI_RP:   rp_q.ki     <= pwdata[GAIN_W-1:0];
        REG_KD_RP:   rp_q.kd     <= pwdata[GAIN_W-1:0];
        REG_KP_YAW:  yaw_q.kp    <= pwdata[GAIN_W-1:0];
        REG_KI_YAW:  yaw_q.ki    <= pwdata[GAIN_W-1:0];
        REG_KD_YAW:  yaw_q.kd    <= pwdata[GAIN_W-1:0];
        REG_LIM_RP:  rp_q.limit  <= pwdata[LIM_W-1:0];
        REG_LIM_YAW: yaw_q.limit <= pwdata[LIM_W-1:0];
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (sel)
      REG_KP_RP:   prdata = CFG_DATA_W'(rp_q.kp);
      REG_KI_RP:   prdata = CFG_DATA_W'(rp_q.ki);
      REG_KD_RP:   prdata = CFG_DATA_W'(rp_q.kd);
      REG_KP_YAW:  prdata = CFG_DATA_W'(yaw_q.kp);
      REG_KI_YAW:  prdata = CFG_DATA_W'(yaw_q.ki);
      REG_KD_YAW:  prdata = CFG_DATA_W'(yaw_q.kd);
      REG_LIM_RP:  prdata = CFG_DATA_W'(rp_q.limit);
      REG_LIM_YAW: prdata = CFG_DATA_W'(yaw_q.limit);
    endcase
  end

  assign rp_gain_o  = rp_q;
  assign yaw_gain_o = yaw_q;

endmodule
`default_nettype wire

[src/qapm_pid_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qapm_pid_lane
// One PID loop: clamped integral, derivative, gain sum and rounded divide.
// ----------------------------------------------------------------------------
module qapm_pid_lane #(
  parameter int unsigned TICKS = qapm_pkg::TICKS_DEFAULT
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           start_i,
  input  wire logic signed [qapm_pkg::ERR_W-1:0]              err_i,
  input  qapm_pkg::gain_t                                     gain_i,
  output logic                                                done_o,
  output logic signed [qapm_pkg::loop_out_w(TICKS)-1:0]       res_o
);
  import qapm_pkg::*;

  localparam int unsigned T_W      = $clog2(TICKS + 1);
  localparam int unsigned N_MAX    = 65535 * 256 + TICKS / 2;
  localparam int unsigned N_W      = $clog2(N_MAX + 1);
  localparam int unsigned RECIP_SH = 32;
  localparam logic [63:0] RECIP    = (64'd1 << RECIP_SH) / TICKS;
  localparam int unsigned R_W      = $clog2(RECIP + 1);
  localparam int unsigned IQ_W     = $clog2(N_MAX / TICKS + 2);
  localparam int unsigned KDT_W    = GAIN_W + T_W;
  localparam int unsigned PA_W     = GAIN_W + ERR_W + 1;
  localparam int unsigned PB_W     = GAIN_W + ACC_W + 1;
  localparam int unsigned PC_W     = KDT_W + NUM_W + 1;
  localparam int unsigned SUM_W    = loop_sum_w(TICKS);
  localparam int unsigned OUT_W    = loop_out_w(TICKS);
  localparam int unsigned A_W      = OUT_W - 1;
  localparam int unsigned ND       = (A_W + 7) / 8;
  localparam int unsigned SH_W     = ND * 8;
  localparam int unsigned DC_W     = $clog2(ND);

  typedef enum logic [3:0] {
    L_IDLE, L_RECIP, L_BACK, L_INTEG, L_MUL, L_SUM, L_ABS, L_DIV, L_SIGN, L_DONE
  } lane_state_e;

  lane_state_e state_q;
  logic [DC_W-1:0] cnt_q;

  // Loop state
  logic signed [ERR_W-1:0] prev_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  // Datapath registers
  logic signed [ERR_W-1:0] err_q;
  logic signed [NUM_W-1:0] num_q;
  logic        [N_W-1:0]   n_q;
  logic                    eneg_q;
  logic        [KDT_W-1:0] kdt_q;
  logic        [IQ_W-1:0]  q0_q;
  logic        [N_W-1:0]   qt_q;
  logic signed [PA_W-1:0]  pa_q;
  logic signed [PB_W-1:0]  pb_q;
  logic signed [PC_W-1:0]  pc_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    sneg_q;
  logic        [SH_W-1:0]  sh_q;
  logic        [SH_W-1:0]  quot_q;
  logic        [2:0]       rem_q;
  logic signed [OUT_W-1:0] res_q;

  logic                    go;
  logic        [ERR_W-2:0] emag_d;
  logic signed [NUM_W-1:0] num_d;
  logic [N_W+R_W-1:0]      rp_d;
  logic [N_W-1:0]          rdiff_d;
  logic [IQ_W-1:0]         qi_d;
  logic signed [IQ_W:0]    step_d;
  logic signed [ACC_W:0]   asum_d, lim_d;
  logic signed [SUM_W-1:0] ea_d, eb_d, ec_d;
  logic [SUM_W-1:0]        mag_d;
  logic [10:0]             x_d, back_d;
  logic [21:0]             prod_d;
  logic [7:0]              qd_d;

  assign go = start_i && (state_q == L_IDLE || state_q == L_DONE);

  // Start values: error magnitude and derivative numerator
  assign emag_d = err_i[ERR_W-1] ? (ERR_W-1)'(-err_i) : err_i[ERR_W-2:0];
  assign num_d  = NUM_W'(err_i) * 7 - NUM_W'(prev_q) * 4;

  // Reciprocal estimate of n / ticks, one low at most
  assign rp_d = N_W'(n_q) * (N_W + R_W)'(R_W'(RECIP));

  // Correct the quotient and step the clamped integral
  assign rdiff_d = n_q - qt_q;
  assign qi_d    = q0_q + IQ_W'(rdiff_d >= N_W'(TICKS));
  assign step_d  = eneg_q ? -$signed({1'b0, qi_d}) : $signed({1'b0, qi_d});
  assign asum_d  = $signed({acc_q[ACC_W-1], acc_q}) + (ACC_W + 1)'(step_d);
  assign lim_d   = $signed({3'b000, gain_i.limit, 8'h00});

  always_comb begin
    if (asum_d > lim_d) begin
      acc_d = ACC_W'(lim_d);
    end else if (asum_d < -lim_d) begin
      acc_d = ACC_W'(-lim_d);
    end else begin
      acc_d = ACC_W'(asum_d);
    end
  end

  // Gain sum: 1280*kp*e + 5*ki*I + 128*kd*ticks*num
  assign ea_d = SUM_W'(pa_q);
  assign eb_d = SUM_W'(pb_q);
  assign ec_d = SUM_W'(pc_q);

  // Magnitude plus half of 20480, then drop the 4096 factor
  assign mag_d = (sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q)) + SUM_W'(10240);

  // One byte of the divide by five: x*1639 >> 13 is exact for x < 1280
  assign x_d    = {rem_q, sh_q[SH_W-1 -: 8]};
  assign prod_d = 22'(x_d) * 22'(1639);
  assign qd_d   = prod_d[20:13];
  assign back_d = {3'b000, qd_d} * 11'd5;

  // Sequencer and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      prev_q  <= '0;
      acc_q   <= '0;
    end else begin
      unique case (state_q)
        L_IDLE, L_DONE: begin
          if (go) begin
            prev_q  <= err_i;
            state_q <= L_RECIP;
          end
        end
        L_RECIP: state_q <= L_BACK;
        L_BACK:  state_q <= L_INTEG;
        L_INTEG: begin
          acc_q   <= acc_d;
          state_q <= L_MUL;
        end
        L_MUL:   state_q <= L_SUM;
        L_SUM:   state_q <= L_ABS;
        L_ABS: begin
          cnt_q   <= '0;
          state_q <= L_DIV;
        end
        L_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DC_W'(ND - 1)) begin
            state_q <= L_SIGN;
          end
        end
        L_SIGN:  state_q <= L_DONE;
        default: state_q <= L_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (go) begin
      err_q  <= err_i;
      num_q  <= num_d;
      eneg_q <= err_i[ERR_W-1];
      n_q    <= N_W'({emag_d, 8'h00}) + N_W'(TICKS / 2);
      kdt_q  <= KDT_W'(gain_i.kd) * KDT_W'(TICKS);
    end
    if (state_q == L_RECIP) begin
      q0_q <= IQ_W'(rp_d >> RECIP_SH);
    end
    if (state_q == L_BACK) begin
      qt_q <= N_W'(q0_q) * N_W'(TICKS);
    end
    if (state_q == L_MUL) begin
      pa_q <= $signed({1'b0, gain_i.kp}) * err_q;
      pb_q <= $signed({1'b0, gain_i.ki}) * acc_q;
      pc_q <= $signed({1'b0, kdt_q}) * num_q;
    end
    if (state_q == L_SUM) begin
      sum_q <= (ea_d <<< 10) + (ea_d <<< 8) + (eb_d <<< 2) + eb_d + (ec_d <<< 7);
    end
    if (state_q == L_ABS) begin
      sneg_q <= sum_q[SUM_W-1];
      sh_q   <= SH_W'(mag_d >> 12);
      rem_q  <= '0;
      quot_q <= '0;
    end
    if (state_q == L_DIV) begin
      sh_q   <= sh_q << 8;
      rem_q  <= 3'(x_d - back_d);
      quot_q <= {quot_q[SH_W-9:0], qd_d};
    end
    if (state_q == L_SIGN) begin
      res_q <= sneg_q ? -$signed({1'b0, quot_q[A_W-1:0]})
                      :  $signed({1'b0, quot_q[A_W-1:0]});
    end
  end

  assign done_o = (state_q == L_DONE);
  assign res_o  = res_q;

endmodule
`default_nettype wire

[src/qapm_mixer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qapm_mixer
// X-frame mixing of the three loop outputs, saturation, output register.
// ----------------------------------------------------------------------------
module qapm_mixer #(
  parameter int unsigned TICKS = qapm_pkg::TICKS_DEFAULT
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           load_i,
  input  wire logic        [qapm_pkg::DATA_W-1:0]             thr_i,
  input  wire logic signed [qapm_pkg::loop_out_w(TICKS)-1:0]  roll_i,
  input  wire logic signed [qapm_pkg::loop_out_w(TICKS)-1:0]  pitch_i,
  input  wire logic signed [qapm_pkg::loop_out_w(TICKS)-1:0]  yaw_i,
  output logic                                                ready_o,
  output logic                                                m_axis_tvalid,
  input  wire logic                                           m_axis_tready,
  output logic             [4*qapm_pkg::DATA_W-1:0]           m_axis_tdata
);
  import qapm_pkg::*;

  localparam int unsigned MIX_W = loop_out_w(TICKS) + 3;

  function automatic logic [DATA_W-1:0] sat_motor(input logic signed [MIX_W-1:0] v);
    logic [DATA_W-1:0] o;
    if (v < 0) begin
      o = '0;
    end else if (v > $signed(MIX_W'(65535))) begin
      o = '1;
    end else begin
      o = v[DATA_W-1:0];
    end
    return o;
  endfunction

  logic signed [MIX_W-1:0] t_w, r_w, p_w, y_w;
  logic signed [MIX_W-1:0] fl_d, fr_d, rl_d, rr_d;
  logic                    valid_q;
  logic [4*DATA_W-1:0]     data_q;

  assign t_w = MIX_W'({1'b0, thr_i});
  assign r_w = MIX_W'(roll_i);
  assign p_w = MIX_W'(pitch_i);
  assign y_w = MIX_W'(yaw_i);

  // X-frame mix
  assign fl_d = t_w + r_w - p_w + y_w;
  assign fr_d = t_w - r_w - p_w - y_w;
  assign rl_d = t_w + r_w + p_w - y_w;
  assign rr_d = t_w - r_w + p_w + y_w;

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // Output word data
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {sat_motor(rr_d), sat_motor(rl_d), sat_motor(fr_d), sat_motor(fl_d)};
    end
  end

  assign ready_o       = !valid_q || m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule
`default_nettype wire

[src/quad_attitude_pid_mixer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quad_attitude_pid_mixer
// Roll, pitch and yaw-rate PID loops with quadcopter X-frame motor mixing.
// ----------------------------------------------------------------------------
// One input word per control tick carries angles, setpoints and throttle; one
// output word carries four saturated motor commands. The three loops run in
// parallel lanes; each lane's serial divide by 20480 works through ND bytes,
// where ND = ceil((clog2(TICKS_PER_SECOND+1) + 34) / 8). The next word can be
// taken in the cycle after the result loads into the output register, and a
// result loads only once the output register can take it.
// The lane sequencer steps through the reciprocal quotient, correction,
// integral clamp, gain products, sum, magnitude, byte-serial divide, then
// sign. The output register lets a new word enter while a result still
// waits. Gains and limits sit on the APB port; the user must write them only
// while the block is idle, as the block itself does not enforce this.
module quad_attitude_pid_mixer #(
  parameter int unsigned TICKS_PER_SECOND = qapm_pkg::TICKS_DEFAULT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input word, from bit 0 up: roll_angle, pitch_angle, roll_setpoint,
  // pitch_setpoint, yaw_rate_setpoint, throttle (16 bits each)
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [6*qapm_pkg::DATA_W-1:0]       s_axis_tdata,
  // Output word, from bit 0 up: motor_front_left, motor_front_right,
  // motor_rear_left, motor_rear_right (16 bits each)
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [4*qapm_pkg::DATA_W-1:0]       m_axis_tdata,
  // Configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [qapm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [qapm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [qapm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready
);
  import qapm_pkg::*;

  localparam int unsigned OUT_W = loop_out_w(TICKS_PER_SECOND);

  typedef enum logic {T_IDLE, T_RUN} top_state_e;

  top_state_e state_q;
  logic [DATA_W-1:0] thr_q;

  gain_t rp_gain, yaw_gain;
  logic  accept, load, mix_ready;
  logic  roll_done, pitch_done, yaw_done;
  logic signed [OUT_W-1:0] roll_res, pitch_res, yaw_res;
  logic signed [ERR_W-1:0] roll_err, pitch_err, yaw_err;
  logic [DATA_W-1:0] roll_ang, pitch_ang, roll_sp, pitch_sp, yaw_sp;

  qapm_cfg_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .rp_gain_o  (rp_gain),
    .yaw_gain_o (yaw_gain)
  );

  // Unpack the input word and form the loop errors
  assign roll_ang  = s_axis_tdata[0*DATA_W +: DATA_W];
  assign pitch_ang = s_axis_tdata[1*DATA_W +: DATA_W];
  assign roll_sp   = s_axis_tdata[2*DATA_W +: DATA_W];
  assign pitch_sp  = s_axis_tdata[3*DATA_W +: DATA_W];
  assign yaw_sp    = s_axis_tdata[4*DATA_W +: DATA_W];

  assign roll_err  = $signed({roll_sp[DATA_W-1], roll_sp})
                   - $signed({roll_ang[DATA_W-1], roll_ang});
  assign pitch_err = $signed({pitch_sp[DATA_W-1], pitch_sp})
                   - $signed({pitch_ang[DATA_W-1], pitch_ang});
  assign yaw_err   = $signed({yaw_sp[DATA_W-1], yaw_sp});

  assign s_axis_tready = (state_q == T_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load          = (state_q == T_RUN) && roll_done && pitch_done && yaw_done
                         && mix_ready;

  // Word control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
    end else begin
      unique case (state_q)
        T_IDLE: if (accept) state_q <= T_RUN;
        T_RUN:  if (load)   state_q <= T_IDLE;
        default: state_q <= T_IDLE;
      endcase
    end
  end

  // Throttle waits beside the lanes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      thr_q <= s_axis_tdata[5*DATA_W +: DATA_W];
    end
  end

  qapm_pid_lane #(.TICKS(TICKS_PER_SECOND)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .err_i   (roll_err),
    .gain_i  (rp_gain),
    .done_o  (roll_done),
    .res_o   (roll_res)
  );

  qapm_pid_lane #(.TICKS(TICKS_PER_SECOND)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .err_i   (pitch_err),
    .gain_i  (rp_gain),
    .done_o  (pitch_done),
    .res_o   (pitch_res)
  );

  qapm_pid_lane #(.TICKS(TICKS_PER_SECOND)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .err_i   (yaw_err),
    .gain_i  (yaw_gain),
    .done_o  (yaw_done),
    .res_o   (yaw_res)
  );

  qapm_mixer #(.TICKS(TICKS_PER_SECOND)) u_mixer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .thr_i         (thr_q),
    .roll_i        (roll_res),
    .pitch_i       (pitch_res),
    .yaw_i         (yaw_res),
    .ready_o       (mix_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

[src/qapm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qapm_checker
// Port-level checks of word flow for the attitude PID mixer.
// ----------------------------------------------------------------------------
module qapm_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [4*qapm_pkg::DATA_W-1:0]     m_axis_tdata
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // One word at a time: input closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accept");

  // Input is still closed at one checked point before the lanes could finish a word
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##8 !s_axis_tready)
    else $error("input reopened before the lanes could finish");

  // Input reopens only when a result has been loaded
  a_reopen_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid)
    else $error("input reopened without a result word");

endmodule

bind quad_attitude_pid_mixer qapm_checker u_qapm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
